// ===== sv/prrv_pkg.sv =====
// ----------------------------------------------------------------------------
// Priority rate-range voter package
// Shared widths, codes, defaults and beat types of the voter block.
// ----------------------------------------------------------------------------
package prrv_pkg;

    localparam int NUM_VOTERS_DEF = 16;
    localparam int VOTE_SLOTS_DEF = 8;

    localparam int RATE_W  = 10;
    localparam int PID_W   = 22;
    localparam int VIDX_W  = 4;
    localparam int VCNT_W  = 5;
    localparam int MASK_W  = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    // Operation codes of an input beat.
    localparam logic OP_DELIVER = 1'b0;
    localparam logic OP_PROCESS = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_VOTER_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_MIN    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_MAX    = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [VCNT_W-1:0] VOTER_COUNT_RST = 5'd1;
    localparam logic [RATE_W-1:0] BASE_MIN_RST    = 10'd0;
    localparam logic [RATE_W-1:0] BASE_MAX_RST    = 10'd120;

    typedef struct packed {
        logic              op;
        logic [VIDX_W-1:0] voter_index;
        logic [PID_W-1:0]  requester_id;
        logic [RATE_W-1:0] vote_min_hz;
        logic [RATE_W-1:0] vote_max_hz;
        logic              event_on;
    } t_vote_in;

    typedef struct packed {
        logic              changed;
        logic [RATE_W-1:0] range_min;
        logic [RATE_W-1:0] range_max;
        logic [MASK_W-1:0] effective_mask;
    } t_vote_out;

    // One stored vote: requester, lower and upper bound.
    typedef struct packed {
        logic [PID_W-1:0]  pid;
        logic [RATE_W-1:0] vmin;
        logic [RATE_W-1:0] vmax;
    } t_vote_entry;

endpackage

// ===== sv/prrv_in_if.sv =====
// ----------------------------------------------------------------------------
// Voter input channel
// Valid/ready channel that carries one deliver or process beat.
// ----------------------------------------------------------------------------
interface prrv_in_if;
    import prrv_pkg::*;

    logic     valid;
    logic     ready;
    t_vote_in data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/prrv_out_if.sv =====
// ----------------------------------------------------------------------------
// Voter result channel
// Valid/ready channel that carries one result beat per input beat.
// ----------------------------------------------------------------------------
interface prrv_out_if;
    import prrv_pkg::*;

    logic      valid;
    logic      ready;
    t_vote_out data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/priority_rate_range_voter_core.sv =====
// ----------------------------------------------------------------------------
// Priority rate-range voter core
// Keeps per-voter vote lists in one synchronous memory and merges the newest
// vote of each voter, in priority order, into one rate range.
// ----------------------------------------------------------------------------
// Sequence: a deliver beat searches the voter's list slot by slot and, when a
//   vote is removed or refreshed, moves the later slots down one by one.
//   Searched and moved slots together never exceed the list length.
//   A process beat scans the voters in order and reads the newest vote of
//   each voter that holds votes, stopping early when the range collapses.
// Throughput: one beat at a time; the next beat is taken as soon as the
//   result has moved into the output register, even while that waits.
// Reset: synchronous, active low. Vote counts, record and effective flags clear
//   at once; the vote memory is not cleared and no clearing pass is needed.
// ----------------------------------------------------------------------------
module priority_rate_range_voter_core #(
    parameter int NUM_VOTERS = prrv_pkg::NUM_VOTERS_DEF,
    parameter int VOTE_SLOTS = prrv_pkg::VOTE_SLOTS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [prrv_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [prrv_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    prrv_in_if.sink                          i_vote,
    prrv_out_if.source                       o_result
);
    import prrv_pkg::*;

    // Index and counter widths. Voters are addressed with VW bits, slots with
    // SW bits; a slot count that can reach VOTE_SLOTS needs CW bits.
    localparam int VW  = (NUM_VOTERS > 1) ? $clog2(NUM_VOTERS) : 1;
    localparam int SW  = (VOTE_SLOTS > 1) ? $clog2(VOTE_SLOTS) : 1;
    localparam int CW  = $clog2(VOTE_SLOTS + 1);
    localparam int VCW = $clog2(NUM_VOTERS + 1);
    localparam int AW  = (VCW > VCNT_W) ? VCW : VCNT_W;
    localparam int XW  = (VW > VIDX_W) ? VW : VIDX_W;
    localparam int MW  = VW + SW;
    localparam int MEM_DEPTH = NUM_VOTERS * (2 ** SW);

    // The sequencer: one-hot states.
    typedef enum logic [8:0] {
        S_IDLE    = 9'b000000001,
        S_START   = 9'b000000010,
        S_SRCH    = 9'b000000100,
        S_SCMP    = 9'b000001000,
        S_SHIFT   = 9'b000010000,
        S_SHWR    = 9'b000100000,
        S_PSCAN   = 9'b001000000,
        S_PNARROW = 9'b010000000,
        S_FINISH  = 9'b100000000
    } t_state;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    t_state             r_state,  n_state;
    t_vote_in           r_item,   n_item;
    logic [VCNT_W-1:0]  r_voter_count;
    logic [RATE_W-1:0]  r_base_min;
    logic [RATE_W-1:0]  r_base_max;

    logic               r_has_rec [NUM_VOTERS];
    logic               n_has_rec [NUM_VOTERS];
    logic               r_eff     [NUM_VOTERS];
    logic               n_eff     [NUM_VOTERS];
    logic [CW-1:0]      r_cnt     [NUM_VOTERS];
    logic [CW-1:0]      n_cnt     [NUM_VOTERS];

    logic [CW-1:0]      r_n, n_n;       // list length of the voter being changed
    logic [CW-1:0]      r_s, n_s;       // search slot
    logic [CW-1:0]      r_k, n_k;       // compaction slot
    logic               r_move, n_move; // a refreshed vote goes to the newest slot
    logic               r_changed, n_changed;
    logic [AW-1:0]      r_pv, n_pv;     // voter scanned by a process beat
    logic [RATE_W-1:0]  r_lo, n_lo;
    logic [RATE_W-1:0]  r_hi, n_hi;

    logic               r_out_valid, n_out_valid;
    t_vote_out          r_out, n_out;

    // Vote memory, one read and one write port, registered read data.
    t_vote_entry        r_mem [MEM_DEPTH];
    t_vote_entry        r_mem_rdata;
    logic               mem_re;
    logic [MW-1:0]      mem_raddr;
    logic               mem_we;
    logic [MW-1:0]      mem_waddr;
    t_vote_entry        mem_wdata;

    // ------------------------------------------------------------------
    // Derived values
    // ------------------------------------------------------------------
    logic [AW-1:0]      active;
    logic [XW-1:0]      v_ext;
    logic [VW-1:0]      vidx;
    logic [VW-1:0]      pvidx;
    logic               in_fire;
    logic               out_fire;
    logic               clear_req;
    logic [MASK_W-1:0]  cur_mask;
    logic [CW-1:0]      n_minus1;
    logic [CW-1:0]      pcnt_minus1;
    logic [RATE_W-1:0]  nar_lo;
    logic [RATE_W-1:0]  nar_hi;
    logic               nar_col;
    t_vote_entry        new_entry;

    // The voter count saturates at the number of voters the memory holds.
    assign active = (AW'(r_voter_count) > AW'(NUM_VOTERS)) ? AW'(NUM_VOTERS)
                                                          : AW'(r_voter_count);
    assign v_ext       = XW'(r_item.voter_index);
    assign vidx        = v_ext[VW-1:0];
    assign pvidx       = r_pv[VW-1:0];
    assign clear_req   = (r_item.requester_id == '0) && !r_item.event_on;
    assign n_minus1    = r_n - CW'(1);
    assign pcnt_minus1 = r_cnt[pvidx] - CW'(1);
    assign new_entry   = '{pid: r_item.requester_id, vmin: r_item.vote_min_hz,
                           vmax: r_item.vote_max_hz};

    assign i_vote.ready   = (r_state == S_IDLE);
    assign in_fire        = i_vote.valid && i_vote.ready;
    assign o_result.valid = r_out_valid;
    assign o_result.data  = r_out;
    assign out_fire       = r_out_valid && o_result.ready;

    // Effective mask of the first sixteen voters: recorded and effective.
    genvar g;
    generate
        for (g = 0; g < MASK_W; g++) begin : g_mask
            if (g < NUM_VOTERS) begin : g_live
                assign cur_mask[g] = r_has_rec[g] && r_eff[g];
            end else begin : g_none
                assign cur_mask[g] = 1'b0;
            end
        end
    endgenerate

    // Narrowing of the running range by the newest vote just read. Raising
    // the low end may collapse the range onto the high end; otherwise the
    // high end may drop and collapse onto the low end.
    always_comb begin
        nar_lo  = r_lo;
        nar_hi  = r_hi;
        nar_col = 1'b0;
        if (r_mem_rdata.vmin > r_lo) begin
            if (r_mem_rdata.vmin >= r_hi) begin
                nar_lo  = r_hi;
                nar_col = 1'b1;
            end else begin
                nar_lo = r_mem_rdata.vmin;
            end
        end
        if (!nar_col) begin
            if (r_mem_rdata.vmax < r_hi) begin
                if (nar_lo >= r_mem_rdata.vmax) begin
                    nar_hi  = nar_lo;
                    nar_col = 1'b1;
                end else begin
                    nar_hi = r_mem_rdata.vmax;
                end
            end
            if (nar_lo == nar_hi) begin
                nar_col = 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        n_state     = r_state;
        n_item      = r_item;
        n_has_rec   = r_has_rec;
        n_eff       = r_eff;
        n_cnt       = r_cnt;
        n_n         = r_n;
        n_s         = r_s;
        n_k         = r_k;
        n_move      = r_move;
        n_changed   = r_changed;
        n_pv        = r_pv;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_out_valid = r_out_valid && !out_fire;
        n_out       = r_out;
        mem_re      = 1'b0;
        mem_raddr   = '0;
        mem_we      = 1'b0;
        mem_waddr   = '0;
        mem_wdata   = new_entry;

        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_item  = i_vote.data;
                    n_state = S_START;
                end
            end

            S_START: begin
                n_changed = 1'b0;
                if (r_item.op == OP_PROCESS) begin
                    n_lo    = r_base_min;
                    n_hi    = r_base_max;
                    n_pv    = '0;
                    n_state = S_PSCAN;
                end else if (AW'(r_item.voter_index) >= active) begin
                    n_state = S_FINISH;
                end else begin
                    // A voter seen for the first time gets a fresh, effective
                    // record, whether or not the change succeeds.
                    n_has_rec[vidx] = 1'b1;
                    if (!r_has_rec[vidx]) begin
                        n_eff[vidx] = 1'b1;
                        n_cnt[vidx] = '0;
                        n_n         = '0;
                    end else begin
                        n_n = r_cnt[vidx];
                    end
                    if (clear_req) begin
                        n_cnt[vidx] = '0;
                        n_changed   = r_has_rec[vidx] && (r_cnt[vidx] != '0);
                        n_state     = S_FINISH;
                    end else begin
                        n_s     = '0;
                        n_state = S_SRCH;
                    end
                end
            end

            S_SRCH: begin
                if (r_s < r_n) begin
                    mem_re    = 1'b1;
                    mem_raddr = {vidx, r_s[SW-1:0]};
                    n_state   = S_SCMP;
                end else begin
                    // Requester not in the list: append an on vote if room is left.
                    if (r_item.event_on && (r_n < CW'(VOTE_SLOTS))) begin
                        mem_we      = 1'b1;
                        mem_waddr   = {vidx, r_n[SW-1:0]};
                        n_cnt[vidx] = r_n + CW'(1);
                        n_changed   = 1'b1;
                    end
                    n_state = S_FINISH;
                end
            end

            S_SCMP: begin
                if (r_mem_rdata.pid == r_item.requester_id) begin
                    if (!r_item.event_on) begin
                        n_k     = r_s;
                        n_move  = 1'b0;
                        n_state = S_SHIFT;
                    end else if ((r_mem_rdata.vmin != r_item.vote_min_hz) ||
                                 (r_mem_rdata.vmax != r_item.vote_max_hz)) begin
                        n_k     = r_s;
                        n_move  = 1'b1;
                        n_state = S_SHIFT;
                    end else begin
                        n_state = S_FINISH;
                    end
                end else begin
                    n_s     = r_s + CW'(1);
                    n_state = S_SRCH;
                end
            end

            S_SHIFT: begin
                // Close the gap one slot at a time, then either shorten the
                // list or place the refreshed vote in the newest slot.
                if ((r_k + CW'(1)) < r_n) begin
                    mem_re    = 1'b1;
                    mem_raddr = {vidx, r_k[SW-1:0] + SW'(1)};
                    n_state   = S_SHWR;
                end else begin
                    if (r_move) begin
                        mem_we    = 1'b1;
                        mem_waddr = {vidx, n_minus1[SW-1:0]};
                    end else begin
                        n_cnt[vidx] = n_minus1;
                    end
                    n_changed = 1'b1;
                    n_state   = S_FINISH;
                end
            end

            S_SHWR: begin
                mem_we    = 1'b1;
                mem_waddr = {vidx, r_k[SW-1:0]};
                mem_wdata = r_mem_rdata;
                n_k       = r_k + CW'(1);
                n_state   = S_SHIFT;
            end

            S_PSCAN: begin
                if (r_pv >= active) begin
                    n_state = S_FINISH;
                end else if (!r_has_rec[pvidx]) begin
                    n_pv = r_pv + AW'(1);
                end else begin
                    n_eff[pvidx] = 1'b1;
                    if (r_cnt[pvidx] == '0) begin
                        n_pv = r_pv + AW'(1);
                    end else begin
                        mem_re    = 1'b1;
                        mem_raddr = {pvidx, pcnt_minus1[SW-1:0]};
                        n_state   = S_PNARROW;
                    end
                end
            end

            S_PNARROW: begin
                n_lo = nar_lo;
                n_hi = nar_hi;
                if (nar_col) begin
                    // Recorded voters below the collapse point lose their say.
                    for (int i = 0; i < NUM_VOTERS; i++) begin
                        if ((AW'(i) > r_pv) && (AW'(i) < active) && r_has_rec[i]) begin
                            n_eff[i] = 1'b0;
                        end
                    end
                    n_state = S_FINISH;
                end else begin
                    n_pv    = r_pv + AW'(1);
                    n_state = S_PSCAN;
                end
            end

            S_FINISH: begin
                if (!r_out_valid || o_result.ready) begin
                    n_out_valid          = 1'b1;
                    n_out.changed        = (r_item.op == OP_DELIVER) && r_changed;
                    n_out.range_min      = (r_item.op == OP_PROCESS) ? r_lo : '0;
                    n_out.range_max      = (r_item.op == OP_PROCESS) ? r_hi : '0;
                    n_out.effective_mask = cur_mask;
                    n_state              = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_out_valid   <= 1'b0;
            r_voter_count <= VOTER_COUNT_RST;
            r_base_min    <= BASE_MIN_RST;
            r_base_max    <= BASE_MAX_RST;
            for (int i = 0; i < NUM_VOTERS; i++) begin
                r_has_rec[i] <= 1'b0;
                r_eff[i]     <= 1'b0;
                r_cnt[i]     <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_has_rec   <= n_has_rec;
            r_eff       <= n_eff;
            r_cnt       <= n_cnt;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_VOTER_COUNT: r_voter_count <= i_cfg_data[VCNT_W-1:0];
                    CFG_BASE_MIN:    r_base_min    <= i_cfg_data[RATE_W-1:0];
                    CFG_BASE_MAX:    r_base_max    <= i_cfg_data[RATE_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // Datapath registers need no reset.
    always_ff @(posedge i_clk) begin
        r_item    <= n_item;
        r_n       <= n_n;
        r_s       <= n_s;
        r_k       <= n_k;
        r_move    <= n_move;
        r_changed <= n_changed;
        r_pv      <= n_pv;
        r_lo      <= n_lo;
        r_hi      <= n_hi;
        r_out     <= n_out;
    end

    // Vote memory. Reads and writes never target the same entry in one cycle:
    // the compaction writes slot k only after reading slot k+1.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_mem_rdata <= r_mem[mem_raddr];
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> (r_state == S_START))
        else $error("accepted beat did not start the sequencer");

    a_search_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCMP) |-> (r_s < r_n))
        else $error("slot compare beyond the list length");

    a_shift_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHWR) |-> ((r_k + CW'(1)) < r_n))
        else $error("compaction write beyond the list length");

    a_list_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SRCH) |-> (r_n <= CW'(VOTE_SLOTS)))
        else $error("vote list longer than the slot count");

    a_finish_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_FINISH) && (!r_out_valid || o_result.ready))
        |=> (r_out_valid && (r_state == S_IDLE)))
        else $error("finished result not loaded into the output register");

endmodule
